// ===== sv/lattice_mirror_height_defines.svh =====
// Assertion helpers used by the RTL in lattice_mirror_height.sv.
`ifndef LATTICE_MIRROR_HEIGHT_DEFINES_SVH
`define LATTICE_MIRROR_HEIGHT_DEFINES_SVH

// Plain property, checked at every rising clock edge while out of reset.
`define LMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication built on the plain form.
`define LMH_ASSERT_IMPL(lbl, pre, post, msg) \
  `LMH_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ===== sv/lmh_pkg.sv =====
package lmh_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC        = 14;

  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [29:0] THREE_ONE = 30'd50331648;
  localparam logic [29:0] NUM_MAX   = 30'd150994944;

  // Phase scale factors: turns per Angstrom along x and along y.
  localparam logic [24:0] KX        = 25'd26443933;
  localparam logic [25:0] KY        = 26'd45802236;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // Division by nine as a reciprocal multiply, exact for any 33-bit numerator.
  localparam logic [29:0] DIV9_MUL   = 30'd954437177;
  localparam int          DIV9_SHIFT = 33;

  // Even cosine polynomial, Horner order from the highest power down.
  localparam logic [30:0] COS_C0 = 31'd331168970;
  localparam logic [30:0] COS_C1 = 31'd1089502240;
  localparam logic [30:0] COS_C2 = 31'd1433727481;
  localparam logic [30:0] COS_C3 = 31'd1010737362;

  // 2^f polynomial: the seed step plus the six multiply steps, Q.24.
  localparam int          EXP_TW     = 26;
  localparam logic [25:0] EXP_C5     = 26'd2584;
  localparam int          EXP_STEPS  = 6;
  localparam logic [25:0] EXP_STEP_C [EXP_STEPS] = '{
    26'd22370, 26'd161365, 26'd931204, 26'd4030332, 26'd11629080, 26'd16777216
  };
  localparam logic [30:0] EXP_LIM = 31'h4000_0000;

  localparam int PIPE_LAT = 23;
  localparam int COS_LAT  = 5;

  localparam int          REG_IDX_W     = 3;
  localparam logic [2:0]  REG_TOP_A     = 3'd0;
  localparam logic [2:0]  REG_TOP_B     = 3'd1;
  localparam logic [2:0]  REG_TOP_C     = 3'd2;
  localparam logic [2:0]  REG_HOLLOW_A  = 3'd3;
  localparam logic [2:0]  REG_HOLLOW_B  = 3'd4;
  localparam logic [2:0]  REG_HOLLOW_C  = 3'd5;
  localparam logic [2:0]  REG_ORIGIN_X  = 3'd6;
  localparam logic [2:0]  REG_ORIGIN_Y  = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] mirror_z;
    logic signed [COORD_WIDTH-1:0] image_z;
    logic                          overflow;
  } res_t;

endpackage

// ===== sv/lmh_cos.sv =====
module lmh_cos (
  input  logic               clk_i,
  input  logic [15:0]        phase_i,
  output logic signed [25:0] cos_o
);
  import lmh_pkg::*;

  logic [16:0] half_fold;
  logic [14:0] u;
  logic        neg;

  // Fold the turn into the first quarter; the second and third quarters flip the sign.
  always_comb begin
    if (phase_i > 16'd32768) begin
      half_fold = 17'd65536 - {1'b0, phase_i};
    end else begin
      half_fold = {1'b0, phase_i};
    end
    if (half_fold > 17'd16384) begin
      u   = 15'(17'd32768 - half_fold);
      neg = 1'b1;
    end else begin
      u   = 15'(half_fold);
      neg = 1'b0;
    end
  end

  logic [28:0] w_q   [1:COS_LAT-1];
  logic        neg_q [1:COS_LAT-1];
  logic [30:0] t2_q, t1_q, t0_q;
  logic [59:0] m2, m1, m0, m9;
  logic signed [26:0] tt;
  logic signed [25:0] mag;

  assign m2 = 60'(w_q[1]) * 60'(COS_C3);
  assign m1 = 60'(w_q[2]) * 60'(t2_q);
  assign m0 = 60'(w_q[3]) * 60'(t1_q);
  assign m9 = 60'(w_q[4]) * 60'(t0_q);

  always_comb begin
    tt = $signed(27'(ONE_Q24)) - $signed(27'(m9[59:32]));
    if (tt < 0) begin
      mag = '0;
    end else begin
      mag = 26'(tt);
    end
  end

  always_ff @(posedge clk_i) begin
    w_q[1]   <= 29'(u) * 29'(u);
    neg_q[1] <= neg;
    for (int k = 2; k < COS_LAT; k++) begin
      w_q[k]   <= w_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
    t2_q  <= COS_C2 - 31'(m2[59:32]);
    t1_q  <= COS_C1 - 31'(m1[59:32]);
    t0_q  <= COS_C0 - 31'(m0[59:32]);
    cos_o <= neg_q[COS_LAT-1] ? -mag : mag;
  end

endmodule

// ===== sv/lattice_mirror_height.sv =====
// Mirror height over a hexagonal surface lattice, one particle per beat.
//
// Input: start qualifies item_i (pos_x, pos_y, pos_z). busy is always low, so
// an item is taken at every clock edge at which start is high, back to back.
// Output: result_valid_o marks result_o for exactly one cycle; the receiver
// must take it then. Results leave in input order, one per accepted item.
// result_valid_o is the last bit of a valid shift register that runs beside the
// data; throughput is one item per cycle. The depth is set by the four-step
// cosine Horner chain, the division by nine, the blend, and the six-step 2^f
// Horner chain, one multiply per Horner step.
// Configuration is an APB-style port, eight 24-bit registers in 32-bit words at
// byte offsets 0x00..0x1C, written at the access cycle; pready is always high.
// Write only while no item is in flight, since stages read the registers live.
// Reset clears the registers and the valid pipeline; items in flight are dropped,
// none is invented across it, and there is no clearing pass.
`include "lattice_mirror_height_defines.svh"

module lattice_mirror_height (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lmh_pkg::pos_t       item_i,
  output logic                result_valid_o,
  output lmh_pkg::res_t       result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lmh_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 28;
  localparam int EW = CW + 27;
  localparam int MW = ((CW > 24) ? CW : 24) + 3;

  // ---------------- configuration registers ----------------
  logic [23:0]   top_a_q, top_b_q, top_c_q, hol_a_q, hol_b_q, hol_c_q;
  logic [CW-1:0] org_x_q, org_y_q;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_a_q <= '0;
      top_b_q <= '0;
      top_c_q <= '0;
      hol_a_q <= '0;
      hol_b_q <= '0;
      hol_c_q <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_TOP_A:    top_a_q <= pwdata[23:0];
        REG_TOP_B:    top_b_q <= pwdata[23:0];
        REG_TOP_C:    top_c_q <= pwdata[23:0];
        REG_HOLLOW_A: hol_a_q <= pwdata[23:0];
        REG_HOLLOW_B: hol_b_q <= pwdata[23:0];
        REG_HOLLOW_C: hol_c_q <= pwdata[23:0];
        REG_ORIGIN_X: org_x_q <= pwdata[CW-1:0];
        REG_ORIGIN_Y: org_y_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TOP_A:    prdata = 32'(top_a_q);
      REG_TOP_B:    prdata = 32'(top_b_q);
      REG_TOP_C:    prdata = 32'(top_c_q);
      REG_HOLLOW_A: prdata = 32'(hol_a_q);
      REG_HOLLOW_B: prdata = 32'(hol_b_q);
      REG_HOLLOW_C: prdata = 32'(hol_c_q);
      REG_ORIGIN_X: prdata = 32'(org_x_q);
      REG_ORIGIN_Y: prdata = 32'(org_y_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- valid pipeline ----------------
  logic [PIPE_LAT:1] v_q;
  logic              accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PIPE_LAT-1:1], accept};
    end
  end

  // z travels alongside for the exponent and the image.
  logic signed [CW-1:0] z_q [1:PIPE_LAT-1];

  always_ff @(posedge clk_i) begin
    z_q[1] <= item_i.pos_z;
    for (int k = 2; k < PIPE_LAT; k++) begin
      z_q[k] <= z_q[k-1];
    end
  end

  // ---------------- phases ----------------
  logic signed [CW:0]   dx_q, dy_q;
  logic signed [PW-1:0] ux_q, uy_q, sum_p, dif_p;

  always_ff @(posedge clk_i) begin
    dx_q <= $signed({item_i.pos_x[CW-1], item_i.pos_x}) - $signed({org_x_q[CW-1], org_x_q});
    dy_q <= $signed({item_i.pos_y[CW-1], item_i.pos_y}) - $signed({org_y_q[CW-1], org_y_q});
    ux_q <= PW'(dx_q) * $signed(PW'(KX));
    uy_q <= PW'(dy_q) * $signed(PW'(KY));
  end

  assign sum_p = ux_q + uy_q;
  assign dif_p = ux_q - uy_q;

  logic signed [25:0] cos1, cos2, cos3;

  lmh_cos u_cos1 (.clk_i(clk_i), .phase_i(ux_q[39:24]),  .cos_o(cos1));
  lmh_cos u_cos2 (.clk_i(clk_i), .phase_i(sum_p[40:25]), .cos_o(cos2));
  lmh_cos u_cos3 (.clk_i(clk_i), .phase_i(dif_p[40:25]), .cos_o(cos3));

  // ---------------- weight gamma ----------------
  logic signed [27:0] ssum;
  logic signed [29:0] num;
  logic [27:0]        np_q;
  logic [57:0]        gp;
  logic [24:0]        g_q;

  always_comb begin
    ssum = 28'(cos1) + 28'(cos2) + 28'(cos3);
    num  = $signed(THREE_ONE) + ($signed(30'(ssum)) <<< 1);
  end

  assign gp = 58'(np_q) * 58'(DIV9_MUL);

  always_ff @(posedge clk_i) begin
    if (num < 0) begin
      np_q <= 28'd4;
    end else if (num > $signed(NUM_MAX)) begin
      np_q <= 28'(NUM_MAX + 30'd4);
    end else begin
      np_q <= 28'(num + 30'sd4);
    end
    g_q <= gp[DIV9_SHIFT+24:DIV9_SHIFT];
  end

  // ---------------- blend ----------------
  function automatic logic [23:0] blend(input logic [23:0] top, input logic [23:0] hol,
                                        input logic [24:0] g);
    logic [49:0] s;
    s = 50'(g) * 50'(top) + 50'(ONE_Q24 - g) * 50'(hol) + 50'(24'h80_0000);
    return s[47:24];
  endfunction

  logic [23:0] a_q, b_q;
  logic [23:0] c_q [10:PIPE_LAT-2];

  always_ff @(posedge clk_i) begin
    a_q     <= blend(top_a_q, hol_a_q, g_q);
    b_q     <= blend(top_b_q, hol_b_q, g_q);
    c_q[10] <= blend(top_c_q, hol_c_q, g_q);
    for (int k = 11; k < PIPE_LAT - 1; k++) begin
      c_q[k] <= c_q[k-1];
    end
  end

  // ---------------- exponent ----------------
  logic signed [EW-1:0] am14, bz, e_q;
  logic signed [63:0]   lp_q;
  logic                 big_q, small_q;

  assign am14 = $signed(EW'({a_q, 14'b0}));
  assign bz   = EW'($signed({1'b0, b_q})) * EW'(z_q[10]);

  always_ff @(posedge clk_i) begin
    e_q     <= (am14 - bz) >>> 6;
    big_q   <= e_q > $signed(EW'(EXP_LIM));
    small_q <= e_q < -$signed(EW'(EXP_LIM));
    lp_q    <= 64'($signed(e_q[31:0])) * $signed(64'(LOG2E_Q30));
  end

  // Integer and fraction of the base-2 exponent.
  logic signed [63:0]   v_w;
  logic signed [8:0]    n_w;
  logic                 nsat;
  logic [23:0]          f_q   [13:19];
  logic signed [8:0]    n_q   [13:20];
  logic                 sat_q [13:PIPE_LAT-2];
  logic                 zro_q [13:20];
  logic [EXP_TW-1:0]    t_q   [14:20];
  logic [EXP_TW-1:0]    step_d [EXP_STEPS];

  assign v_w  = lp_q >>> 30;
  assign n_w  = v_w[32:24];
  assign nsat = n_w >= $signed(9'(CW - FRAC));

  always_comb begin
    for (int j = 0; j < EXP_STEPS; j++) begin
      logic [49:0] prod;
      prod      = 50'(f_q[14+j]) * 50'(t_q[14+j]);
      step_d[j] = EXP_STEP_C[j] + prod[49:24];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q[13]   <= v_w[23:0];
    n_q[13]   <= n_w;
    sat_q[13] <= big_q || (!small_q && nsat);
    zro_q[13] <= small_q && !big_q;
    for (int k = 14; k < 20; k++) begin
      f_q[k] <= f_q[k-1];
    end
    for (int k = 14; k <= 20; k++) begin
      n_q[k]   <= n_q[k-1];
      zro_q[k] <= zro_q[k-1];
    end
    for (int k = 14; k < PIPE_LAT - 1; k++) begin
      sat_q[k] <= sat_q[k-1];
    end
    t_q[14] <= EXP_C5 + EXP_TW'(f_q[13][23:16]);
    for (int j = 0; j < EXP_STEPS; j++) begin
      t_q[15+j] <= step_d[j];
    end
  end

  // ---------------- scale to Q.14 ----------------
  logic signed [9:0] sh;
  logic [9:0]        rsh;
  logic [CW+1:0]     ex_d, ex_q;
  logic [CW+EXP_TW+9:0] lwide;

  assign sh    = 10'(n_q[20]) - 10'sd10;
  assign rsh   = 10'(-sh);
  assign lwide = (CW + EXP_TW + 10)'(t_q[20]) << sh[3:0];

  always_comb begin
    if (sat_q[20]) begin
      ex_d = (CW+2)'(1) << CW;
    end else if (zro_q[20]) begin
      ex_d = '0;
    end else if (sh >= 0) begin
      ex_d = lwide[CW+1:0];
    end else if (rsh >= 10'(EXP_TW)) begin
      ex_d = '0;
    end else begin
      ex_d = (CW+2)'(t_q[20] >> rsh[4:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q <= ex_d;
  end

  // ---------------- mirror and image ----------------
  localparam logic signed [MW-1:0] M_HI = MW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [MW-1:0] M_LO = -M_HI - MW'(1);
  localparam logic signed [CW+1:0] I_HI = (CW+2)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CW+1:0] I_LO = -I_HI - (CW+2)'(1);

  logic signed [MW-1:0]   md;
  logic signed [CW-1:0]   mir_q;
  logic                   ovf_q;
  logic signed [CW+1:0]   id;
  res_t                   res_d, res_q;

  assign md = $signed(MW'(c_q[PIPE_LAT-2])) - $signed(MW'(ex_q));
  assign id = ($signed((CW+2)'(mir_q)) <<< 1) - (CW+2)'(z_q[PIPE_LAT-1]);

  always_ff @(posedge clk_i) begin
    if (md > M_HI) begin
      mir_q <= M_HI[CW-1:0];
      ovf_q <= 1'b1;
    end else if (md < M_LO) begin
      mir_q <= M_LO[CW-1:0];
      ovf_q <= 1'b1;
    end else begin
      mir_q <= md[CW-1:0];
      ovf_q <= sat_q[PIPE_LAT-2];
    end
  end

  always_comb begin
    res_d.mirror_z = mir_q;
    res_d.overflow = ovf_q;
    if (id > I_HI) begin
      res_d.image_z  = I_HI[CW-1:0];
      res_d.overflow = 1'b1;
    end else if (id < I_LO) begin
      res_d.image_z  = I_LO[CW-1:0];
      res_d.overflow = 1'b1;
    end else begin
      res_d.image_z = id[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = v_q[PIPE_LAT];

  // ---------------- checks ----------------
  `LMH_ASSERT_IMPL(a_result_follows_item, result_valid_o, $past(accept, PIPE_LAT), "result without an item")
  `LMH_ASSERT_IMPL(a_exp_sat_flags, v_q[13] && sat_q[13], ##(PIPE_LAT - 13) result_o.overflow, "saturated exponential lost its flag")
  `LMH_ASSERT_IMPL(a_gamma_range, v_q[9], (g_q <= ONE_Q24) && ($past(np_q) <= 28'(NUM_MAX + 30'd4)), "gamma out of range")

endmodule
